@@ rtl/dmkr_pkg.sv @@
// ============================================================================
// dmkr_pkg
// Shared types and constants for the distinct miss key recorder.
// ============================================================================
package dmkr_pkg;

    localparam int KEY_W    = 32;
    localparam int STORED_W = 10;
    localparam int OVF_W    = 32;

    // One miss event
    typedef struct packed {
        logic [KEY_W-1:0] miss_address;
        logic             compact_mode;
    } miss_t;

    // One result word
    typedef struct packed {
        logic [KEY_W-1:0]    recorded_key;
        logic [STORED_W-1:0] distinct_stored;
        logic [OVF_W-1:0]    overflow_total;
        logic [OVF_W-1:0]    miss_total;
        logic                key_was_new;
        logic                key_was_stored;
    } result_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

endpackage

@@ rtl/dmkr_miss_if.sv @@
// ============================================================================
// dmkr_miss_if
// Valid/ready channel carrying one miss event word.
// ============================================================================
interface dmkr_miss_if
    import dmkr_pkg::*;
();
    logic  valid;
    logic  ready;
    miss_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/dmkr_result_if.sv @@
// ============================================================================
// dmkr_result_if
// Valid/ready channel carrying one result word.
// ============================================================================
interface dmkr_result_if
    import dmkr_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/distinct_miss_key_recorder.sv @@
// ============================================================================
// distinct_miss_key_recorder
// Records distinct miss keys in a key memory, searched linearly per event.
// ============================================================================
//  channel  dir  modport  word
//  -------  ---  -------  --------------------------------------------------
//  miss     in   sink     miss_address, compact_mode
//  result   out  source   recorded_key, distinct_stored, overflow_total,
//                         miss_total, key_was_new, key_was_stored
//
//  An event passes through an accept step, one memory read per stored key
//  with the compare on the registered read data, and an update step; a hit
//  ends the search early.
//  The key memory has one port used for reads during the search and for the
//  append write in the update cycle. Reset clears counters and control only.
//  A result waiting at the output does not block the next accept; the update
//  cycle waits until the output register is free.
// ============================================================================
module distinct_miss_key_recorder
    import dmkr_pkg::*;
#(
    parameter int CAPACITY = 512
) (
    input  logic           clk,
    input  logic           rst_n,
    dmkr_miss_if.sink      miss,
    dmkr_result_if.source  result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // Registers
    state_t            state_reg,    state_next;
    logic [KEY_W-1:0]  key_reg,      key_next;
    logic [CW-1:0]     idx_reg,      idx_next;
    logic              cmp_vld_reg,  cmp_vld_next;
    logic              hit_reg,      hit_next;
    logic [CW-1:0]     count_reg,    count_next;
    logic [OVF_W-1:0]  ovf_reg,      ovf_next;
    logic              out_vld_reg,  out_vld_next;
    result_t           out_reg,      out_next;

    // Key memory
    logic [KEY_W-1:0]  key_mem [CAPACITY];
    logic [KEY_W-1:0]  mem_q_reg;
    logic              mem_re;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;

    logic              found;
    logic              out_free;
    logic [OVF_W:0]    total_sum;
    logic              is_new;
    logic              do_store;

    assign miss.ready   = (state_reg == ST_IDLE);
    assign result.valid = out_vld_reg;
    assign result.data  = out_reg;

    assign found    = cmp_vld_reg && (mem_q_reg == key_reg);
    assign out_free = !out_vld_reg || result.ready;

    // Sequencer and update logic
    always_comb
    begin
        state_next   = state_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        cmp_vld_next = 1'b0;
        hit_next     = hit_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        out_vld_next = out_vld_reg && !result.ready;
        out_next     = out_reg;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_addr     = idx_reg[AW-1:0];
        is_new       = !hit_reg;
        do_store     = 1'b0;
        total_sum    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (miss.valid)
                begin
                    key_next   = {miss.data.miss_address[KEY_W-1:1],
                                  miss.data.compact_mode};
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // issue next read while comparing the previous one
                if (found)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (idx_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    mem_addr = count_reg[AW-1:0];
                    if (is_new)
                    begin
                        if (count_reg < CAP_CNT)
                        begin
                            do_store   = 1'b1;
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        else if (ovf_reg != {OVF_W{1'b1}})
                        begin
                            ovf_next = ovf_reg + 1'b1;
                        end
                    end
                    // saturating total
                    total_sum = {1'b0, OVF_W'(count_next)} + {1'b0, ovf_next};
                    out_next.recorded_key    = key_reg;
                    out_next.distinct_stored = STORED_W'(count_next);
                    out_next.overflow_total  = ovf_next;
                    out_next.miss_total      = total_sum[OVF_W] ? {OVF_W{1'b1}}
                                                                : total_sum[OVF_W-1:0];
                    out_next.key_was_new     = is_new;
                    out_next.key_was_stored  = do_store;
                    out_vld_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            count_reg   <= '0;
            ovf_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_reg     <= hit_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        out_reg <= out_next;
    end

    // Key memory: single port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_addr] <= key_reg;
        end
        if (mem_re)
        begin
            mem_q_reg <= key_mem[mem_addr];
        end
    end

endmodule

@@ test/distinct_miss_key_recorder_test.sv @@
`timescale 1ns / 100ps
// ============================================================================
// distinct_miss_key_recorder_test
// Self-checking bench for the distinct miss key recorder. Miss events are
// queued up front: a directed set of edge keys first, then random traffic
// that mixes fresh keys, repeats, mode twins and one-bit neighbors of keys
// already sent, enough to fill the key store and run into overflow. Every
// accepted miss word is run through a local model of the recorder and each
// result word is compared field by field against the oldest prediction.
// ============================================================================
module distinct_miss_key_recorder_test;
    import dmkr_pkg::*;

    localparam int CAPACITY     = 512;
    localparam int RANDOM_ITEMS = 1130;
    localparam int HOLD_AT      = 200;      // accepted words before the long stall
    localparam int HOLD_CYCLES  = 4000;
    localparam int LIMIT_CYCLES = 3000000;

    // Pending miss word plus a flag that makes the driver drain first
    typedef struct {
        miss_t ev;
        bit    wait_drain;
    } queued_miss_t;

    logic clk = 1'b0;
    logic rst_n;

    dmkr_miss_if   miss_ch ();
    dmkr_result_if result_ch ();

    distinct_miss_key_recorder #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .miss   (miss_ch),
        .result (result_ch)
    );

    queued_miss_t pending_misses[$];
    result_t      expected_results[$];
    logic [31:0]  offered_keys[$];

    // Model state
    logic [31:0]  held_keys[$];
    logic [31:0]  overflow_seen = '0;

    int total_items     = 1;
    int misses_accepted = 0;
    int hold_left       = 0;
    bit hold_armed      = 1'b1;
    int mismatches      = 0;
    int cycle_count     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected result of one miss event; updates the model state
    function automatic result_t record_miss(miss_t ev);
        result_t     r;
        logic [31:0] key;
        logic [32:0] sum;
        bit          found;
        key   = {ev.miss_address[31:1], ev.compact_mode};
        found = 1'b0;
        foreach (held_keys[i])
        begin
            if (held_keys[i] == key)
                found = 1'b1;
        end
        r.recorded_key   = key;
        r.key_was_new    = !found;
        r.key_was_stored = 1'b0;
        if (!found)
        begin
            if (held_keys.size() < CAPACITY)
            begin
                held_keys.push_back(key);
                r.key_was_stored = 1'b1;
            end
            else if (overflow_seen != 32'hFFFF_FFFF)
            begin
                overflow_seen = overflow_seen + 32'd1;
            end
        end
        sum = 33'(held_keys.size()) + 33'(overflow_seen);
        r.distinct_stored = STORED_W'(held_keys.size());
        r.overflow_total  = overflow_seen;
        r.miss_total      = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        return r;
    endfunction

    // Idle percentage per side: sender light / receiver heavy, then swapped,
    // then no idling at all
    function automatic int idle_pct(bit receiver);
        int third;
        third = misses_accepted / ((total_items + 2) / 3);
        if (third == 0)
            return receiver ? 56 : 20;
        else if (third == 1)
            return receiver ? 20 : 56;
        return 0;
    endfunction

    function automatic void queue_miss(logic [31:0] addr, logic mode, bit wait_drain);
        queued_miss_t q;
        q.ev.miss_address = addr;
        q.ev.compact_mode = mode;
        q.wait_drain      = wait_drain;
        pending_misses.push_back(q);
        offered_keys.push_back({addr[31:1], mode});
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
        end
    endtask

    // Driver: offers the head of the pending queue, holds it until taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            miss_ch.valid <= 1'b0;
        end
        else if (!(miss_ch.valid && !miss_ch.ready))
        begin
            if (miss_ch.valid)
            begin
                expected_results.push_back(record_miss(pending_misses[0].ev));
                void'(pending_misses.pop_front());
                misses_accepted <= misses_accepted + 1;
            end
            if (pending_misses.size() > 0
                && !(pending_misses[0].wait_drain && expected_results.size() > 0)
                && $urandom_range(0, 99) >= idle_pct(1'b0))
            begin
                miss_ch.valid <= 1'b1;
                miss_ch.data  <= pending_misses[0].ev;
            end
            else
            begin
                miss_ch.valid <= 1'b0;
            end
        end
    end

    // One long receiver stall once traffic is flowing
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_armed && misses_accepted >= HOLD_AT)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
    end

    // Monitor: checks each taken result word against the oldest prediction
    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.data;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result word: expected none, got %h", $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("recorded_key", want.recorded_key, got.recorded_key);
                    check_field("distinct_stored", 32'(want.distinct_stored),
                                32'(got.distinct_stored));
                    check_field("overflow_total", want.overflow_total, got.overflow_total);
                    check_field("miss_total", want.miss_total, got.miss_total);
                    check_field("key_was_new", 32'(want.key_was_new), 32'(got.key_was_new));
                    check_field("key_was_stored", 32'(want.key_was_stored),
                                32'(got.key_was_stored));
                end
            end
            result_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1));
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("** distinct_miss_key_recorder: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int          pick;
        logic [31:0] known;
        bit          drain;

        miss_ch.valid   = 1'b0;
        miss_ch.data    = '0;
        result_ch.ready = 1'b0;
        rst_n           = 1'b0;

        // Directed: extreme keys, ignored address bit 0, mode twins, repeats
        queue_miss(32'h0000_0000, 1'b0, 1'b0);
        queue_miss(32'h0000_0000, 1'b0, 1'b0);
        queue_miss(32'h0000_0001, 1'b0, 1'b0);
        queue_miss(32'h0000_0000, 1'b1, 1'b0);
        queue_miss(32'h0000_0001, 1'b1, 1'b0);
        queue_miss(32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_miss(32'hFFFF_FFFE, 1'b1, 1'b0);
        queue_miss(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_miss(32'h8000_0000, 1'b0, 1'b0);
        queue_miss(32'h7FFF_FFFF, 1'b1, 1'b0);
        queue_miss(32'hAAAA_AAAA, 1'b1, 1'b0);
        queue_miss(32'h5555_5555, 1'b0, 1'b0);
        queue_miss(32'hAAAA_AAAB, 1'b1, 1'b0);
        queue_miss(32'h5555_5554, 1'b0, 1'b0);
        queue_miss(32'h0000_0002, 1'b0, 1'b0);
        queue_miss(32'h0000_0001, 1'b0, 1'b0);

        // Random: fresh keys fill the store and push into overflow; repeats,
        // mode twins and one-bit neighbors stress the key compare
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick  = $urandom_range(0, 99);
            known = offered_keys[$urandom_range(0, offered_keys.size() - 1)];
            drain = (n == 430) || (n == 930);
            if (pick < 50)
                queue_miss($urandom, 1'($urandom_range(0, 1)), drain);
            else if (pick < 80)
                queue_miss({known[31:1], 1'($urandom_range(0, 1))}, known[0], drain);
            else if (pick < 90)
                queue_miss({known[31:1], 1'($urandom_range(0, 1))}, ~known[0], drain);
            else
                queue_miss(known ^ (32'd1 << $urandom_range(1, 31)),
                           1'($urandom_range(0, 1)), drain);
        end
        total_items = pending_misses.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all words taken, all results in, then one full search time
        while (pending_misses.size() > 0 || miss_ch.valid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (CAPACITY + 16) @(posedge clk);

        if (mismatches == 0)
            $display("** distinct_miss_key_recorder: PASSED **");
        else
            $display("** distinct_miss_key_recorder: FAILED **");
        $finish;
    end

endmodule
